// ===== rtl/lscr_pkg.sv =====
// Shared types and constants for the slot cache unit.
// Used by lscr_cell and the top level; no dependencies.
`default_nettype none
package lscr_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SLOTS_MAX     = 256;
   localparam logic [6:0] SPAN_RESET = 7'd64;

   // operation codes
   localparam logic [2:0] OP_LOOKUP  = 3'd0;
   localparam logic [2:0] OP_ALLOC   = 3'd1;
   localparam logic [2:0] OP_RELEASE = 3'd2;
   localparam logic [2:0] OP_REVIVE  = 3'd3;
   localparam logic [2:0] OP_PROBE   = 3'd4;
   localparam logic [2:0] OP_CLEAR   = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISS     = 2'd1;
   localparam logic [1:0] ST_DUP      = 2'd2;

   typedef enum logic [1:0] {
      REC_NONE,
      REC_REMOVE,
      REC_PUSH,
      REC_CLEAR
   } rec_type;

   // search results carried along the chain; indices and ranks sized for SLOTS_MAX
   typedef struct packed {
      logic        act_hit;
      logic [7:0]  act_idx;
      logic        act_mem;
      logic [7:0]  act_rank;
      logic        fm_hit;
      logic [7:0]  fm_idx;
      logic [7:0]  fm_rank;
      logic        old_hit;
      logic [7:0]  old_idx;
      logic [7:0]  old_rank;
      logic        vic_hit;
      logic [7:0]  vic_idx;
      logic [7:0]  vic_rank;
      logic [63:0] vic_tag;
      logic        tm_hit;
      logic [7:0]  tm_idx;
      logic [63:0] tm_tag;
      logic [8:0]  free_cnt;
   } cand_type;

   // state update broadcast to every cell
   typedef struct packed {
      logic [7:0]  sel;
      logic        take;
      logic [7:0]  take_rank;
      logic        add;
      logic [7:0]  add_rank;
      rec_type     rec;
      logic        rec_mem;
      logic [7:0]  rec_rank;
      logic        set_tag;
      logic [63:0] tag;
   } cmd_type;

endpackage
`default_nettype wire

// ===== rtl/lscr_cell.sv =====
// One slot of the pool: tag, free-order and recency state, and one search stage.
// Depends on lscr_pkg.
`default_nettype none
module lscr_cell #(
   parameter int SLOTS = lscr_pkg::SLOTS_DEFAULT,
   parameter int IDX   = 0
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [$clog2(SLOTS+1)-1:0] span,
   input  wire logic [63:0]                scan_tag,
   input  wire lscr_pkg::cand_type         cand_prev,
   output      lscr_pkg::cand_type         cand_next,
   input  wire logic                       cmd_valid,
   input  wire lscr_pkg::cmd_type          cmd
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SW = $clog2(SLOTS+1);

   logic [63:0]   tag_ff,   tag_in;
   logic          active_ff, active_in;
   logic [IW-1:0] frank_ff, frank_in;
   logic [IW-1:0] rrank_ff, rrank_in;
   logic          mem_ff,   mem_in;
   lscr_pkg::cand_type cand_ff, cand_in;

   logic       en, match, is_sel;
   logic [7:0] frank8, rrank8, idx8;

   assign idx8   = 8'(IDX);
   assign frank8 = 8'(frank_ff);
   assign rrank8 = 8'(rrank_ff);
   assign en     = SW'(IDX) < span;
   assign match  = tag_ff == scan_tag;
   assign is_sel = cmd.sel == idx8;

   always_comb begin
      cand_in = cand_prev;
      if (en && active_ff && match && !cand_prev.act_hit) begin
         cand_in.act_hit  = 1'b1;
         cand_in.act_idx  = idx8;
         cand_in.act_mem  = mem_ff;
         cand_in.act_rank = rrank8;
      end
      if (en && !active_ff && match && (!cand_prev.fm_hit || frank8 > cand_prev.fm_rank)) begin
         cand_in.fm_hit  = 1'b1;
         cand_in.fm_idx  = idx8;
         cand_in.fm_rank = frank8;
      end
      if (en && !active_ff && (!cand_prev.old_hit || frank8 < cand_prev.old_rank)) begin
         cand_in.old_hit  = 1'b1;
         cand_in.old_idx  = idx8;
         cand_in.old_rank = frank8;
      end
      if (en && active_ff && mem_ff && (!cand_prev.vic_hit || rrank8 > cand_prev.vic_rank)) begin
         cand_in.vic_hit  = 1'b1;
         cand_in.vic_idx  = idx8;
         cand_in.vic_rank = rrank8;
         cand_in.vic_tag  = tag_ff;
      end
      if (en && active_ff && (!cand_prev.tm_hit || tag_ff > cand_prev.tm_tag)) begin
         cand_in.tm_hit = 1'b1;
         cand_in.tm_idx = idx8;
         cand_in.tm_tag = tag_ff;
      end
      // free count runs over the whole pool, not just the span
      if (!active_ff) cand_in.free_cnt = cand_prev.free_cnt + 9'd1;
   end

   always_comb begin
      tag_in    = tag_ff;
      active_in = active_ff;
      frank_in  = frank_ff;
      rrank_in  = rrank_ff;
      mem_in    = mem_ff;
      if (cmd_valid) begin
         if (cmd.take) begin
            if (is_sel) begin
               active_in = 1'b1;
               frank_in  = '0;
            end else if (!active_ff && frank8 > cmd.take_rank) begin
               frank_in = frank_ff - IW'(1);
            end
         end
         if (cmd.add && is_sel) begin
            active_in = 1'b0;
            frank_in  = IW'(cmd.add_rank);
         end
         case (cmd.rec)
            lscr_pkg::REC_REMOVE: begin
               if (is_sel) begin
                  mem_in   = 1'b0;
                  rrank_in = '0;
               end else if (cmd.rec_mem && mem_ff && rrank8 > cmd.rec_rank) begin
                  rrank_in = rrank_ff - IW'(1);
               end
            end
            lscr_pkg::REC_PUSH: begin
               if (is_sel) begin
                  mem_in   = 1'b1;
                  rrank_in = '0;
               end else if (mem_ff && (!cmd.rec_mem || rrank8 < cmd.rec_rank)) begin
                  rrank_in = rrank_ff + IW'(1);
               end
            end
            lscr_pkg::REC_CLEAR: begin
               mem_in   = 1'b0;
               rrank_in = '0;
            end
            default: ;
         endcase
         if (cmd.set_tag && is_sel) tag_in = cmd.tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff    <= '1;
         active_ff <= 1'b0;
         frank_ff  <= IW'(IDX);
         rrank_ff  <= '0;
         mem_ff    <= 1'b0;
         cand_ff   <= '0;
      end else begin
         tag_ff    <= tag_in;
         active_ff <= active_in;
         frank_ff  <= frank_in;
         rrank_ff  <= rrank_in;
         mem_ff    <= mem_in;
         cand_ff   <= cand_in;
      end
   end

   assign cand_next = cand_ff;

endmodule
`default_nettype wire

// ===== rtl/lru_slot_cache_with_free_reuse_unit.sv =====
// Top level of the slot cache: request sequencer, span register, chain of slot cells.
// Depends on lscr_pkg and lscr_cell.
`default_nettype none
// The response follows two passes down the chain of SLOTS cells: the search result
// ripples one cell per cycle down the chain, the chosen update is then applied to
// every cell at once, and a second pass down the chain, long enough that the last
// cell has seen the updated state, reports whether any slot of the span is still
// free. One request is in flight at a time; req_ready is high while idle, so a new
// request is accepted only after the last response has been taken. The
// slots_in_use register is written through csr_we/csr_wdata; the user must write it
// only while idle, as the block itself does not enforce this.
module lru_slot_cache_with_free_reuse_unit #(
   parameter int SLOTS = lscr_pkg::SLOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_operation,
   input  wire logic [63:0] req_tag,
   input  wire logic        req_search_free,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [5:0]  rsp_slot,
   output      logic [1:0]  rsp_status,
   output      logic        rsp_is_active,
   output      logic        rsp_in_free_list,
   output      logic        rsp_evicted,
   output      logic [63:0] rsp_evicted_tag,
   output      logic        rsp_free_available,
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata
);
   localparam int SW = $clog2(SLOTS+1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN1, S_DECIDE, S_SCAN2, S_RESP} state_type;

   state_type     state_ff;
   logic [SW-1:0] cnt_ff;
   logic [6:0]    csr_ff;
   logic [2:0]    op_ff;
   logic [63:0]   tag_ff;
   logic          search_ff;
   logic [7:0]    slot_ff;
   logic [1:0]    status_ff;
   logic          act_ff, infree_ff, ev_ff, avail_ff;
   logic [63:0]   evtag_ff;

   logic [SW-1:0] span;
   lscr_pkg::cand_type chain [SLOTS+1];
   lscr_pkg::cand_type tail;
   lscr_pkg::cmd_type  cmd;
   logic          cmd_valid;
   logic [7:0]    slot_in;
   logic [1:0]    status_in;
   logic          act_in, infree_in, ev_in;
   logic [63:0]   evtag_in;

   always_comb begin
      if (csr_ff == 7'd0) span = SW'(1);
      else if (10'(csr_ff) > 10'(SLOTS)) span = SW'(SLOTS);
      else span = SW'(csr_ff);
   end

   assign chain[0] = '0;
   assign tail     = chain[SLOTS];

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      lscr_cell #(.SLOTS(SLOTS), .IDX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .span      (span),
         .scan_tag  (tag_ff),
         .cand_prev (chain[i]),
         .cand_next (chain[i+1]),
         .cmd_valid (cmd_valid),
         .cmd       (cmd)
      );
   end

   assign cmd_valid = state_ff == S_DECIDE;

   always_comb begin
      cmd       = '0;
      cmd.rec   = lscr_pkg::REC_NONE;
      cmd.tag   = tag_ff;
      slot_in   = '0;
      status_in = lscr_pkg::ST_OK;
      act_in    = 1'b0;
      infree_in = 1'b0;
      ev_in     = 1'b0;
      evtag_in  = '0;
      case (op_ff)
         lscr_pkg::OP_LOOKUP: begin
            if (tail.act_hit) begin
               slot_in      = tail.act_idx;
               cmd.sel      = tail.act_idx;
               cmd.rec      = lscr_pkg::REC_PUSH;
               cmd.rec_mem  = tail.act_mem;
               cmd.rec_rank = tail.act_rank;
            end else if (search_ff && tail.fm_hit) begin
               slot_in       = tail.fm_idx;
               cmd.sel       = tail.fm_idx;
               cmd.take      = 1'b1;
               cmd.take_rank = tail.fm_rank;
               cmd.rec       = lscr_pkg::REC_PUSH;
            end else begin
               status_in = lscr_pkg::ST_MISS;
            end
         end
         lscr_pkg::OP_ALLOC: begin
            if (tail.act_hit) begin
               status_in = lscr_pkg::ST_DUP;
               slot_in   = tail.act_idx;
            end else if (tail.old_hit) begin
               slot_in       = tail.old_idx;
               cmd.sel       = tail.old_idx;
               cmd.take      = 1'b1;
               cmd.take_rank = tail.old_rank;
               cmd.set_tag   = 1'b1;
            end else if (tail.vic_hit) begin
               slot_in      = tail.vic_idx;
               cmd.sel      = tail.vic_idx;
               cmd.rec      = lscr_pkg::REC_REMOVE;
               cmd.rec_mem  = 1'b1;
               cmd.rec_rank = tail.vic_rank;
               cmd.set_tag  = 1'b1;
               ev_in        = 1'b1;
               evtag_in     = tail.vic_tag;
            end else if (tail.tm_hit) begin
               // empty recency list: greatest tag goes; it is not on the list
               slot_in     = tail.tm_idx;
               cmd.sel     = tail.tm_idx;
               cmd.set_tag = 1'b1;
               ev_in       = 1'b1;
               evtag_in    = tail.tm_tag;
            end else begin
               status_in = lscr_pkg::ST_MISS;
            end
         end
         lscr_pkg::OP_RELEASE: begin
            if (tail.act_hit) begin
               slot_in      = tail.act_idx;
               cmd.sel      = tail.act_idx;
               cmd.add      = 1'b1;
               cmd.add_rank = tail.free_cnt[7:0];
               cmd.rec      = lscr_pkg::REC_REMOVE;
               cmd.rec_mem  = tail.act_mem;
               cmd.rec_rank = tail.act_rank;
            end else begin
               status_in = lscr_pkg::ST_MISS;
            end
         end
         lscr_pkg::OP_REVIVE: begin
            if (tail.act_hit) begin
               status_in = lscr_pkg::ST_DUP;
               slot_in   = tail.act_idx;
            end else if (tail.fm_hit) begin
               slot_in       = tail.fm_idx;
               cmd.sel       = tail.fm_idx;
               cmd.take      = 1'b1;
               cmd.take_rank = tail.fm_rank;
            end else begin
               status_in = lscr_pkg::ST_MISS;
            end
         end
         lscr_pkg::OP_PROBE: begin
            act_in    = tail.act_hit;
            infree_in = tail.fm_hit;
         end
         lscr_pkg::OP_CLEAR: cmd.rec = lscr_pkg::REC_CLEAR;
         default: status_in = lscr_pkg::ST_MISS;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         csr_ff   <= lscr_pkg::SPAN_RESET;
      end else begin
         if (csr_we) csr_ff <= csr_wdata;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_operation;
                  tag_ff    <= req_tag;
                  search_ff <= req_search_free;
                  cnt_ff    <= '0;
                  state_ff  <= S_SCAN1;
               end
            end
            S_SCAN1: begin
               cnt_ff <= cnt_ff + SW'(1);
               if (cnt_ff == SW'(SLOTS-1)) state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               slot_ff   <= slot_in;
               status_ff <= status_in;
               act_ff    <= act_in;
               infree_ff <= infree_in;
               ev_ff     <= ev_in;
               evtag_ff  <= evtag_in;
               cnt_ff    <= '0;
               state_ff  <= S_SCAN2;
            end
            S_SCAN2: begin
               cnt_ff <= cnt_ff + SW'(1);
               // the last cell holds the updated state once cnt_ff reaches SLOTS, so avail is taken then
               if (cnt_ff == SW'(SLOTS)) begin
                  avail_ff <= tail.old_hit;
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready          = state_ff == S_IDLE;
   assign rsp_valid          = state_ff == S_RESP;
   assign rsp_slot           = slot_ff[5:0];
   assign rsp_status         = status_ff;
   assign rsp_is_active      = act_ff;
   assign rsp_in_free_list   = infree_ff;
   assign rsp_evicted        = ev_ff;
   assign rsp_evicted_tag    = evtag_ff;
   assign rsp_free_available = avail_ff;

endmodule
`default_nettype wire
